@@ src/etpi_pkg.sv @@
package etpi_pkg;

    // fixed-point format and field widths
    localparam int COORD_WIDTH = 64;
    localparam int FRAC_BITS   = 60;
    localparam int PIXEL_BITS  = 12;
    localparam int COUNT_BITS  = 16;
    localparam int STEP_WIDTH  = COORD_WIDTH - 1;

    // operand magnitude fed to the multiplier chain (values up to 2.0)
    localparam int MAG_WIDTH  = FRAC_BITS + 2;
    localparam int DIGIT      = 16;
    localparam int NUM_CELLS  = COORD_WIDTH / DIGIT;
    localparam int B_WIDTH    = NUM_CELLS * DIGIT;
    localparam int ACC_WIDTH  = 2 * B_WIDTH;

    localparam int CFG_INDEX_BITS = 3;

    localparam logic [COORD_WIDTH-1:0] FX_TWO   = COORD_WIDTH'(2) << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] FX_THREE = COORD_WIDTH'(3) << FRAC_BITS;
    localparam logic [COORD_WIDTH:0]   FX_FOUR  = (COORD_WIDTH+1)'(4) << FRAC_BITS;
    localparam logic [COORD_WIDTH-1:0] SAT_MAX  = {1'b0, {(COORD_WIDTH-1){1'b1}}};

    localparam logic [COORD_WIDTH-1:0] ORIGIN_REAL_RST =
        COORD_WIDTH'(0) - (COORD_WIDTH'(3) << (FRAC_BITS - 1));
    localparam logic [COORD_WIDTH-1:0] ORIGIN_IMAG_RST =
        COORD_WIDTH'(0) - (COORD_WIDTH'(1) << FRAC_BITS);
    localparam logic [STEP_WIDTH-1:0]  PIXEL_STEP_RST  = STEP_WIDTH'(1) << (FRAC_BITS - 8);
    localparam logic [COUNT_BITS-1:0]  LIMIT_RST       = COUNT_BITS'(100);

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_ORIGIN_REAL,
        REG_ORIGIN_IMAG,
        REG_PIXEL_STEP,
        REG_ITER_LIMIT,
        REG_PREV_LIMIT
    } cfg_reg_t;

    typedef enum logic [1:0] {
        TAG_XX,
        TAG_YY,
        TAG_XY
    } prod_tag_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COORD_MUL,
        S_COORD_SUM,
        S_STEP,
        S_ISSUE,
        S_WAIT,
        S_CHECK,
        S_DONE
    } state_t;

    typedef struct packed {
        logic                 valid;
        prod_tag_t            tag;
        logic [MAG_WIDTH-1:0] a;
        logic [B_WIDTH-1:0]   b;
        logic [ACC_WIDTH-1:0] acc;
    } mul_stage_t;

endpackage

@@ src/escape_time_pixel_iterator.sv @@
// escape-time pixel iterator: one result item per input item
// sequence: a reused count or a zero limit goes straight to the result; otherwise the coordinates are formed
// and each iteration takes one complex step, three product issues and a pass through the multiplier chain
// throughput: one item at a time; the next item is taken once the result sits in the output register
// reset: rst_n asynchronous active low; registers return to a 512x512 view of
// [-1.5-1i, 0.5+1i] with limits of 100, no item in flight
module escape_time_pixel_iterator (
    input  logic        clk,
    input  logic        rst_n,
    // input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // pixel_row[11:0], pixel_column[23:12], prior_count[39:24]
    // result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // escape_count[15:0]
    output logic [0:0]  m_axis_tuser,   // was_reused[0]
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int CW      = etpi_pkg::COORD_WIDTH;
    localparam int PB      = etpi_pkg::PIXEL_BITS;
    localparam int CB      = etpi_pkg::COUNT_BITS;
    localparam int PROD_W  = PB + etpi_pkg::STEP_WIDTH;
    localparam int CSUM_W  = PROD_W + 2;
    localparam int WIDE_W  = CW + 2;

    // saturate a wide signed sum to +-(2^63-1)
    function automatic logic signed [CW-1:0] sat_wide(input logic signed [WIDE_W-1:0] v);
        logic signed [WIDE_W-1:0] hi;
        hi = $signed({2'b00, etpi_pkg::SAT_MAX});
        if (v > hi)
            return $signed(etpi_pkg::SAT_MAX);
        else if (v < -hi)
            return -$signed(etpi_pkg::SAT_MAX);
        else
            return v[CW-1:0];
    endfunction

    // magnitude of a value that never reaches the most negative code
    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // origin + index*step, clamped to +-3.0
    function automatic logic signed [CW-1:0] coord_clamp(input logic [PROD_W-1:0] prod,
                                                         input logic signed [CW-1:0] org);
        logic signed [CSUM_W-1:0] s;
        logic signed [CSUM_W-1:0] three;
        three = $signed(CSUM_W'(etpi_pkg::FX_THREE));
        s     = $signed({2'b00, prod}) + $signed({{(CSUM_W-CW){org[CW-1]}}, org});
        if (s > three)
            return $signed(etpi_pkg::FX_THREE);
        else if (s < -three)
            return -$signed(etpi_pkg::FX_THREE);
        else
            return s[CW-1:0];
    endfunction

    // configuration registers
    logic signed [CW-1:0]                  origin_real_reg, origin_imag_reg;
    logic [etpi_pkg::STEP_WIDTH-1:0]       pixel_step_reg;
    logic [CB-1:0]                         iteration_limit_reg, previous_limit_reg;

    // control
    etpi_pkg::state_t                      state_reg, state_next;
    etpi_pkg::prod_tag_t                   issue_reg, issue_next;
    logic                                  m_valid_reg, m_valid_next;

    // datapath
    logic [PB-1:0]                         row_reg, row_next, col_reg, col_next;
    logic [PROD_W-1:0]                     prod_re_reg, prod_re_next, prod_im_reg, prod_im_next;
    logic signed [CW-1:0]                  cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0]                  x_reg, x_next, y_reg, y_next;
    logic [CW-1:0]                         xs_reg, xs_next, ys_reg, ys_next;
    logic [CW-1:0]                         pxy_reg, pxy_next;
    logic                                  neg_reg, neg_next;
    logic [CB-1:0]                         iter_reg, iter_next;
    logic [CB-1:0]                         res_count_reg, res_count_next;
    logic                                  res_reused_reg, res_reused_next;
    logic [CB-1:0]                         m_count_reg, m_count_next;
    logic                                  m_reused_reg, m_reused_next;

    // input fields
    logic [PB-1:0]                         in_row, in_col;
    logic [CB-1:0]                         in_prior;
    logic                                  in_fire, reuse;

    // step arithmetic
    logic [WIDE_W-2:0]                     p2;
    logic signed [WIDE_W-1:0]              ysum, xsum;
    logic signed [CW-1:0]                  x_sat, y_sat;
    logic [CW-1:0]                         xm_new, ym_new, xm_cur, ym_cur;
    logic [CW:0]                           sumsq;
    logic [CB-1:0]                         iter_inc;

    etpi_pkg::mul_stage_t                  chain_in, chain_out;
    logic [CW-1:0]                         chain_res;

    assign in_row   = s_axis_tdata[PB-1:0];
    assign in_col   = s_axis_tdata[2*PB-1:PB];
    assign in_prior = s_axis_tdata[2*PB+CB-1:2*PB];

    assign s_axis_tready = (state_reg == etpi_pkg::S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    // a count from the last pass still holds if the limit moved past it
    assign reuse = ((previous_limit_reg < iteration_limit_reg) && (in_prior < previous_limit_reg))
                || ((previous_limit_reg > iteration_limit_reg) && (in_prior > iteration_limit_reg));

    // z update: y = 2xy + cy, x = x^2 - y^2 + cx, both saturated
    assign p2     = {pxy_reg, 1'b0};
    assign ysum   = (neg_reg ? -$signed({1'b0, p2}) : $signed({1'b0, p2}))
                  + $signed({{2{cy_reg[CW-1]}}, cy_reg});
    assign xsum   = $signed({2'b00, xs_reg}) - $signed({2'b00, ys_reg})
                  + $signed({{2{cx_reg[CW-1]}}, cx_reg});
    assign x_sat  = sat_wide(xsum);
    assign y_sat  = sat_wide(ysum);
    assign xm_new = mag(x_sat);
    assign ym_new = mag(y_sat);
    assign xm_cur = mag(x_reg);
    assign ym_cur = mag(y_reg);
    assign sumsq  = {1'b0, xs_reg} + {1'b0, ys_reg};
    assign iter_inc = iter_reg + CB'(1);

    // three products per iteration share the chain, one issued per cycle
    always_comb
    begin
        chain_in       = '0;
        chain_in.valid = (state_reg == etpi_pkg::S_ISSUE);
        chain_in.tag   = issue_reg;
        unique case (issue_reg)
            etpi_pkg::TAG_XX:
            begin
                chain_in.a = xm_cur[etpi_pkg::MAG_WIDTH-1:0];
                chain_in.b = etpi_pkg::B_WIDTH'(xm_cur[etpi_pkg::MAG_WIDTH-1:0]);
            end
            etpi_pkg::TAG_YY:
            begin
                chain_in.a = ym_cur[etpi_pkg::MAG_WIDTH-1:0];
                chain_in.b = etpi_pkg::B_WIDTH'(ym_cur[etpi_pkg::MAG_WIDTH-1:0]);
            end
            default:
            begin
                chain_in.a = xm_cur[etpi_pkg::MAG_WIDTH-1:0];
                chain_in.b = etpi_pkg::B_WIDTH'(ym_cur[etpi_pkg::MAG_WIDTH-1:0]);
            end
        endcase
    end

    etpi_mul_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .chain_in  (chain_in),
        .chain_out (chain_out)
    );

    // product truncated to the fixed-point grid
    assign chain_res = chain_out.acc[etpi_pkg::FRAC_BITS +: CW];

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        issue_next      = issue_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        prod_re_next    = prod_re_reg;
        prod_im_next    = prod_im_reg;
        cx_next         = cx_reg;
        cy_next         = cy_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        xs_next         = xs_reg;
        ys_next         = ys_reg;
        pxy_next        = pxy_reg;
        neg_next        = neg_reg;
        iter_next       = iter_reg;
        res_count_next  = res_count_reg;
        res_reused_next = res_reused_reg;
        m_count_next    = m_count_reg;
        m_reused_next   = m_reused_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;

        // results leave the chain in issue order
        if (chain_out.valid)
        begin
            unique case (chain_out.tag)
                etpi_pkg::TAG_XX: xs_next  = chain_res;
                etpi_pkg::TAG_YY: ys_next  = chain_res;
                default:          pxy_next = chain_res;
            endcase
        end

        unique case (state_reg)
            etpi_pkg::S_IDLE:
            begin
                if (in_fire)
                begin
                    row_next = in_row;
                    col_next = in_col;
                    if (reuse)
                    begin
                        res_count_next  = in_prior;
                        res_reused_next = 1'b1;
                        state_next      = etpi_pkg::S_DONE;
                    end
                    else if (iteration_limit_reg == '0)
                    begin
                        res_count_next  = '0;
                        res_reused_next = 1'b0;
                        state_next      = etpi_pkg::S_DONE;
                    end
                    else
                    begin
                        res_reused_next = 1'b0;
                        state_next      = etpi_pkg::S_COORD_MUL;
                    end
                end
            end
            etpi_pkg::S_COORD_MUL:
            begin
                prod_re_next = PROD_W'(col_reg) * PROD_W'(pixel_step_reg);
                prod_im_next = PROD_W'(row_reg) * PROD_W'(pixel_step_reg);
                state_next   = etpi_pkg::S_COORD_SUM;
            end
            etpi_pkg::S_COORD_SUM:
            begin
                cx_next    = coord_clamp(prod_re_reg, origin_real_reg);
                cy_next    = coord_clamp(prod_im_reg, origin_imag_reg);
                xs_next    = '0;
                ys_next    = '0;
                pxy_next   = '0;
                neg_next   = 1'b0;
                iter_next  = '0;
                state_next = etpi_pkg::S_STEP;
            end
            etpi_pkg::S_STEP:
            begin
                x_next   = x_sat;
                y_next   = y_sat;
                neg_next = x_sat[CW-1] != y_sat[CW-1];
                // a component beyond 2.0 has escaped without the squares
                if (xm_new > etpi_pkg::FX_TWO || ym_new > etpi_pkg::FX_TWO)
                begin
                    res_count_next = iter_reg;
                    state_next     = etpi_pkg::S_DONE;
                end
                else
                begin
                    issue_next = etpi_pkg::TAG_XX;
                    state_next = etpi_pkg::S_ISSUE;
                end
            end
            etpi_pkg::S_ISSUE:
            begin
                unique case (issue_reg)
                    etpi_pkg::TAG_XX: issue_next = etpi_pkg::TAG_YY;
                    etpi_pkg::TAG_YY: issue_next = etpi_pkg::TAG_XY;
                    default:          state_next = etpi_pkg::S_WAIT;
                endcase
            end
            etpi_pkg::S_WAIT:
            begin
                if (chain_out.valid && chain_out.tag == etpi_pkg::TAG_XY)
                    state_next = etpi_pkg::S_CHECK;
            end
            etpi_pkg::S_CHECK:
            begin
                if (sumsq > etpi_pkg::FX_FOUR)
                begin
                    res_count_next = iter_reg;
                    state_next     = etpi_pkg::S_DONE;
                end
                else if (iter_inc == iteration_limit_reg)
                begin
                    res_count_next = iteration_limit_reg;
                    state_next     = etpi_pkg::S_DONE;
                end
                else
                begin
                    iter_next  = iter_inc;
                    state_next = etpi_pkg::S_STEP;
                end
            end
            etpi_pkg::S_DONE:
            begin
                // hand over to the output register once it is free
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_count_next  = res_count_reg;
                    m_reused_next = res_reused_reg;
                    m_valid_next  = 1'b1;
                    state_next    = etpi_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = etpi_pkg::S_IDLE;
            end
        endcase
    end

    // control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= etpi_pkg::S_IDLE;
            issue_reg           <= etpi_pkg::TAG_XX;
            m_valid_reg         <= 1'b0;
            origin_real_reg     <= $signed(etpi_pkg::ORIGIN_REAL_RST);
            origin_imag_reg     <= $signed(etpi_pkg::ORIGIN_IMAG_RST);
            pixel_step_reg      <= etpi_pkg::PIXEL_STEP_RST;
            iteration_limit_reg <= etpi_pkg::LIMIT_RST;
            previous_limit_reg  <= etpi_pkg::LIMIT_RST;
        end
        else
        begin
            state_reg   <= state_next;
            issue_reg   <= issue_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    etpi_pkg::REG_ORIGIN_REAL: origin_real_reg     <= $signed(cfg_data);
                    etpi_pkg::REG_ORIGIN_IMAG: origin_imag_reg     <= $signed(cfg_data);
                    etpi_pkg::REG_PIXEL_STEP:  pixel_step_reg      <= cfg_data[etpi_pkg::STEP_WIDTH-1:0];
                    etpi_pkg::REG_ITER_LIMIT:  iteration_limit_reg <= cfg_data[CB-1:0];
                    etpi_pkg::REG_PREV_LIMIT:  previous_limit_reg  <= cfg_data[CB-1:0];
                    default: ;  // unknown index ignored
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        row_reg        <= row_next;
        col_reg        <= col_next;
        prod_re_reg    <= prod_re_next;
        prod_im_reg    <= prod_im_next;
        cx_reg         <= cx_next;
        cy_reg         <= cy_next;
        x_reg          <= x_next;
        y_reg          <= y_next;
        xs_reg         <= xs_next;
        ys_reg         <= ys_next;
        pxy_reg        <= pxy_next;
        neg_reg        <= neg_next;
        iter_reg       <= iter_next;
        res_count_reg  <= res_count_next;
        res_reused_reg <= res_reused_next;
        m_count_reg    <= m_count_next;
        m_reused_reg   <= m_reused_next;
    end

    assign m_axis_tvalid   = m_valid_reg;
    assign m_axis_tdata    = m_count_reg;
    assign m_axis_tuser[0] = m_reused_reg;

endmodule

@@ src/etpi_mul_cell.sv @@
module etpi_mul_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  etpi_pkg::mul_stage_t stage_in,
    output etpi_pkg::mul_stage_t stage_out
);

    localparam int PP_WIDTH = etpi_pkg::MAG_WIDTH + etpi_pkg::DIGIT;

    logic [PP_WIDTH-1:0]      pp;
    etpi_pkg::mul_stage_t     stage_next;
    etpi_pkg::mul_stage_t     stage_reg;

    // one digit of b per cell, top digit first, accumulator shifts up
    always_comb
    begin
        pp = PP_WIDTH'(stage_in.a)
             * PP_WIDTH'(stage_in.b[etpi_pkg::B_WIDTH-1 -: etpi_pkg::DIGIT]);
        stage_next       = stage_in;
        stage_next.acc   = {stage_in.acc[etpi_pkg::ACC_WIDTH-etpi_pkg::DIGIT-1:0],
                            etpi_pkg::DIGIT'(0)} + etpi_pkg::ACC_WIDTH'(pp);
        stage_next.b     = {stage_in.b[etpi_pkg::B_WIDTH-etpi_pkg::DIGIT-1:0],
                            etpi_pkg::DIGIT'(0)};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg.valid <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

@@ src/etpi_mul_chain.sv @@
module etpi_mul_chain (
    input  logic                 clk,
    input  logic                 rst_n,
    input  etpi_pkg::mul_stage_t chain_in,
    output etpi_pkg::mul_stage_t chain_out
);

    etpi_pkg::mul_stage_t link [etpi_pkg::NUM_CELLS+1];

    assign link[0] = chain_in;

    for (genvar k = 0; k < etpi_pkg::NUM_CELLS; k++)
    begin : g_cell
        etpi_mul_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (link[k]),
            .stage_out (link[k+1])
        );
    end

    assign chain_out = link[etpi_pkg::NUM_CELLS];

endmodule

@@ src/etpi_checker.sv @@
module etpi_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [15:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    // stalled result keeps valid
    a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result item dropped while stalled");

    // stalled result keeps its payload
    a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result item changed while stalled");

    // one item at a time: busy after an accept
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // a new result only appears at the end of an item's work
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("result item with no item in work");

endmodule

bind escape_time_pixel_iterator etpi_checker u_etpi_checker (.*);

@@ sim/tb_escape_time_pixel_iterator.sv @@
module tb_escape_time_pixel_iterator;

    // bench-only code for a register slot that the block does not decode
    localparam logic [2:0] REG_UNDECODED = 3'd7;
    localparam int         STALL_LIMIT   = 20000;

    // scoreboard: a private copy of the view registers, a predictor of the escape
    // count and a queue of the counts still owed by the block
    class escape_count_book;

        typedef struct {
            logic [15:0] count;
            logic        reused;
        } escape_result_t;

        longint         view_real   = longint'(etpi_pkg::ORIGIN_REAL_RST);
        longint         view_imag   = longint'(etpi_pkg::ORIGIN_IMAG_RST);
        logic [62:0]    view_step   = etpi_pkg::PIXEL_STEP_RST;
        logic [15:0]    limit_now   = etpi_pkg::LIMIT_RST;
        logic [15:0]    limit_prev  = etpi_pkg::LIMIT_RST;
        escape_result_t owed_counts[$];
        int             errors;

        function void write_reg(logic [2:0] idx, logic [63:0] value);
            case (idx)
                etpi_pkg::REG_ORIGIN_REAL: view_real  = longint'(value);
                etpi_pkg::REG_ORIGIN_IMAG: view_imag  = longint'(value);
                etpi_pkg::REG_PIXEL_STEP:  view_step  = value[62:0];
                etpi_pkg::REG_ITER_LIMIT:  limit_now  = value[15:0];
                etpi_pkg::REG_PREV_LIMIT:  limit_prev = value[15:0];
                default: ;
            endcase
        endfunction

        function logic [63:0] mag64(longint v);
            return v < 0 ? 64'(-v) : 64'(v);
        endfunction

        // |a|*|b| cut to the fixed-point fraction, saturating
        function logic [63:0] mag_product(logic [63:0] a, logic [63:0] b);
            logic [127:0] p;
            p = {64'd0, a} * {64'd0, b};
            if (p[127:124] != 4'd0)
                return '1;
            return p[123:60];
        endfunction

        function longint signed_clip(bit neg, logic [63:0] m);
            if (m > 64'h7fff_ffff_ffff_ffff)
                m = 64'h7fff_ffff_ffff_ffff;
            return neg ? -longint'(m) : longint'(m);
        endfunction

        // saturates to the symmetric range, never to the most negative word
        function longint clip_sum(longint a, longint b);
            logic signed [64:0] s;
            logic signed [64:0] top;
            top = 65'sh0_7fff_ffff_ffff_ffff;
            s = 65'(a) + 65'(b);
            if (s > top)
                return longint'(top[63:0]);
            if (s < -top)
                return -longint'(top[63:0]);
            return longint'(s[63:0]);
        endfunction

        // origin + index*step, held within +-3.0
        function longint pixel_coord(longint org, logic [11:0] idx);
            logic [127:0]        p;
            logic signed [129:0] s;
            logic signed [129:0] three;
            p = 128'(idx) * 128'(view_step);
            three = $signed({66'd0, etpi_pkg::FX_THREE});
            s = $signed({2'b00, p}) + 130'(org);
            if (s > three)
                return longint'(etpi_pkg::FX_THREE);
            if (s < -three)
                return -longint'(etpi_pkg::FX_THREE);
            return longint'(s[63:0]);
        endfunction

        function logic [15:0] escape_iteration(longint cx, longint cy);
            longint      x, y;
            logic [63:0] xs, ys, xm, ym, p;
            x = 0;
            y = 0;
            xs = 0;
            ys = 0;
            for (int it = 0; it < int'(limit_now); it++)
            begin
                p = mag_product(mag64(x), mag64(y));
                p = p[63] ? '1 : p << 1;
                y = clip_sum(signed_clip((x < 0) != (y < 0), p), cy);
                x = clip_sum(longint'(xs) - longint'(ys), cx);
                xm = mag64(x);
                ym = mag64(y);
                // a component beyond 2 has escaped already
                if (xm > etpi_pkg::FX_TWO || ym > etpi_pkg::FX_TWO)
                    return 16'(it);
                xs = mag_product(xm, xm);
                ys = mag_product(ym, ym);
                if ({1'b0, xs} + {1'b0, ys} > etpi_pkg::FX_FOUR)
                    return 16'(it);
            end
            return limit_now;
        endfunction

        function void note_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] prior);
            escape_result_t r;
            // a count from a pass with a different limit may still hold
            if ((limit_prev < limit_now && prior < limit_prev) ||
                (limit_prev > limit_now && prior > limit_now))
            begin
                r.count  = prior;
                r.reused = 1'b1;
            end
            else
            begin
                r.count  = escape_iteration(pixel_coord(view_real, col),
                                            pixel_coord(view_imag, row));
                r.reused = 1'b0;
            end
            owed_counts.insert(owed_counts.size(), r);
        endfunction

        function void check_count(logic [15:0] count, logic reused);
            escape_result_t r;
            if (owed_counts.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result item: count %0d reused %0d", count, reused);
                return;
            end
            r = owed_counts.pop_front();
            if (count !== r.count || reused !== r.reused)
            begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected count %0d reused %0d, got %0d reused %0d",
                             r.count, r.reused, count, reused);
            end
        endfunction

    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    escape_count_book book;

    // idling controls for the two sides
    bit tx_idle;
    bit rx_stall;
    int hold_left;
    int quiet_cycles;

    escape_time_pixel_iterator dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // receiver: a long hold-off when asked, otherwise random stalls by phase
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready = 1'b0;
                hold_left--;
            end
            else
                m_axis_tready = !(rx_stall && $urandom_range(99) < 83);
        end
    end

    // result checking and the no-progress watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
                book.check_count(m_axis_tdata, m_axis_tuser[0]);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("escape_time_pixel_iterator: mismatch");
                $finish;
            end
        end
    end

    task automatic send_pixel(logic [11:0] row, logic [11:0] col, logic [15:0] prior);
        @(negedge clk);
        while (tx_idle && $urandom_range(99) < 83)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {prior, col, row};
        do
            @(posedge clk);
        while (!s_axis_tready);
        book.note_pixel(row, col, prior);
    endtask

    // stop offering and wait until every owed count has come back
    task automatic wait_drained();
        @(negedge clk);
        s_axis_tvalid = 1'b0;
        while (book.owed_counts.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        book.write_reg(idx, value);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_view(longint re, longint im, logic [62:0] step,
                            logic [15:0] lim, logic [15:0] prev);
        wait_drained();
        write_reg(etpi_pkg::REG_ORIGIN_REAL, 64'(re));
        write_reg(etpi_pkg::REG_ORIGIN_IMAG, 64'(im));
        write_reg(etpi_pkg::REG_PIXEL_STEP, {1'b0, step});
        write_reg(etpi_pkg::REG_ITER_LIMIT, {48'd0, lim});
        write_reg(etpi_pkg::REG_PREV_LIMIT, {48'd0, prev});
    endtask

    // a random view: mostly near the set, sometimes anywhere in the word range
    task automatic random_view();
        longint      re, im;
        logic [62:0] step;
        if ($urandom_range(4) == 0)
        begin
            re = longint'({$urandom, $urandom});
            im = longint'({$urandom, $urandom});
        end
        else
        begin
            re = -longint'(64'($urandom_range(512, 2560)) << 50);
            im = -longint'(64'($urandom_range(0, 1536)) << 50);
        end
        if ($urandom_range(9) == 0)
            step = 63'({$urandom, $urandom});
        else
            step = 63'($urandom_range(1, 4096)) << 38;
        set_view(re, im, step, 16'($urandom_range(0, 40)), 16'($urandom_range(0, 40)));
        if ($urandom_range(3) == 0)
            write_reg(REG_UNDECODED, {$urandom, $urandom});
    endtask

    task automatic random_pixel();
        logic [11:0] row, col;
        logic [15:0] prior;
        row   = $urandom_range(1) ? 12'($urandom_range(0, 600)) : 12'($urandom);
        col   = $urandom_range(1) ? 12'($urandom_range(0, 600)) : 12'($urandom);
        prior = $urandom_range(1) ? 16'($urandom_range(0, 45)) : 16'($urandom);
        send_pixel(row, col, prior);
    endtask

    initial
    begin
        book          = new;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = etpi_pkg::REG_ORIGIN_REAL;
        cfg_data      = '0;
        tx_idle       = 1'b0;
        rx_stall      = 1'b0;
        hold_left     = 0;
        quiet_cycles  = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset view: field extremes and two points inside the set
        send_pixel(12'd0, 12'd0, 16'd0);
        send_pixel(12'hfff, 12'hfff, 16'hffff);
        send_pixel(12'd256, 12'd256, 16'd0);
        send_pixel(12'd256, 12'd384, 16'd7);

        // raised limit: counts below the old limit are kept
        set_view(longint'(etpi_pkg::ORIGIN_REAL_RST), longint'(etpi_pkg::ORIGIN_IMAG_RST),
                 etpi_pkg::PIXEL_STEP_RST, 16'd10, 16'd5);
        send_pixel(12'd256, 12'd256, 16'd4);
        send_pixel(12'd256, 12'd256, 16'd5);
        send_pixel(12'd100, 12'd20, 16'hffff);

        // lowered limit: counts above the new limit are kept
        wait_drained();
        write_reg(etpi_pkg::REG_PREV_LIMIT, 64'd40);
        send_pixel(12'd256, 12'd256, 16'd11);
        send_pixel(12'd256, 12'd256, 16'd10);

        // zero limit
        set_view(longint'(etpi_pkg::ORIGIN_REAL_RST), longint'(etpi_pkg::ORIGIN_IMAG_RST),
                 etpi_pkg::PIXEL_STEP_RST, 16'd0, 16'd0);
        send_pixel(12'd256, 12'd256, 16'd3);

        // zero step puts every pixel on the origin
        set_view(0, 0, 63'd0, 16'd20, 16'd20);
        send_pixel(12'hfff, 12'hfff, 16'd0);
        send_pixel(12'd0, 12'd0, 16'hffff);

        // extreme origins and step, largest limit: everything escapes at once
        set_view(longint'(etpi_pkg::SAT_MAX), longint'(~etpi_pkg::SAT_MAX), '1,
                 16'hffff, 16'hffff);
        send_pixel(12'd0, 12'd0, 16'd0);
        send_pixel(12'hfff, 12'hfff, 16'hffff);
        set_view(longint'(~etpi_pkg::SAT_MAX), longint'(etpi_pkg::SAT_MAX), 63'd1,
                 16'hffff, 16'd1);
        send_pixel(12'd0, 12'hfff, 16'd0);
        wait_drained();
        write_reg(REG_UNDECODED, '1);
        send_pixel(12'hfff, 12'd0, 16'hfffe);

        // long receiver hold-off with the sender still offering items
        set_view(longint'(etpi_pkg::ORIGIN_REAL_RST), longint'(etpi_pkg::ORIGIN_IMAG_RST),
                 etpi_pkg::PIXEL_STEP_RST, 16'd8, 16'd8);
        @(posedge clk);
        hold_left = 400;
        for (int i = 0; i < 6; i++)
            random_pixel();
        // sender pauses until every result is back
        wait_drained();

        // random phases: no idling, sender idle, receiver stalls, both
        for (int phase = 0; phase < 4; phase++)
        begin
            tx_idle  = (phase == 1) || (phase == 3);
            rx_stall = (phase == 2) || (phase == 3);
            for (int blk = 0; blk < 4; blk++)
            begin
                random_view();
                for (int i = 0; i < 50; i++)
                    random_pixel();
            end
        end

        wait_drained();
        if (book.errors == 0)
            $display("escape_time_pixel_iterator: match");
        else
            $display("escape_time_pixel_iterator: mismatch");
        $finish;
    end

endmodule
